/* design/prru_pkg.sv */
package prru_pkg;

  // Fixed field widths of the transfer payload.
  localparam int unsigned PermW     = 24;
  localparam int unsigned CodeW     = 16;
  localparam int unsigned ElemW     = 3;
  localparam int unsigned PermSlots = PermW / ElemW;

  typedef enum logic {
    OP_RANK   = 1'b0,
    OP_UNRANK = 1'b1
  } op_e;

  // Per-stage payload carried down the unranking chain.
  typedef struct packed {
    op_e              op;
    logic             bad;
    logic [CodeW-1:0] code;
    logic [CodeW-1:0] rem;
    logic [PermW-1:0] perm;
  } stage_t;

  // Elaboration-time factorial; only ever called with constant arguments.
  function automatic longint unsigned factorial(input int unsigned k);
    longint unsigned f;
    f = 1;
    for (int unsigned j = 2; j <= k; j++) begin
      f = f * longint'(j);
    end
    return f;
  endfunction

endpackage

/* design/prru_lane.sv */
module prru_lane #(
  parameter int unsigned ELEMENTS = 8,
  parameter int unsigned INDEX    = 0
) (
  input  logic [ELEMENTS-1:0][prru_pkg::ElemW-1:0] elems_i,
  output logic [prru_pkg::CodeW-1:0]               term_o,
  output logic                                     bad_o
);
  import prru_pkg::*;

  localparam int unsigned CntW = $clog2(ELEMENTS);
  localparam int unsigned CmpW = ($clog2(ELEMENTS + 1) > ElemW) ? $clog2(ELEMENTS + 1) : ElemW;
  localparam logic [CodeW-1:0] Weight = CodeW'(factorial(ELEMENTS - 1 - INDEX));

  logic [CntW-1:0]  cnt;
  logic             dup;
  logic             out_of_range;
  logic [CodeW-1:0] cnt_ext;

  // Count the smaller values to the right of this position and look for repeats.
  always_comb begin
    cnt = '0;
    dup = 1'b0;
    for (int unsigned j = INDEX + 1; j < ELEMENTS; j++) begin
      if (elems_i[j] < elems_i[INDEX]) begin
        cnt = cnt + CntW'(1);
      end
      if (elems_i[j] == elems_i[INDEX]) begin
        dup = 1'b1;
      end
    end
  end

  // A value must lie below the element count.
  assign out_of_range = CmpW'(elems_i[INDEX]) >= CmpW'(ELEMENTS);

  // Weight the count by the factorial of the positions to the right.
  assign cnt_ext = CodeW'(cnt);
  assign term_o  = cnt_ext * Weight;
  assign bad_o   = dup | out_of_range;

endmodule

/* design/prru_merge.sv */
module prru_merge #(
  parameter int unsigned ELEMENTS = 8
) (
  input  logic [ELEMENTS-1:0][prru_pkg::CodeW-1:0] terms_i,
  output logic [prru_pkg::CodeW-1:0]               sum_o
);
  import prru_pkg::*;

  // Add the weighted lane counts; the rank wraps at the code width.
  always_comb begin
    sum_o = '0;
    for (int unsigned i = 0; i < ELEMENTS; i++) begin
      sum_o = sum_o + terms_i[i];
    end
  end

endmodule

/* design/prru_pick.sv */
module prru_pick #(
  parameter int unsigned ELEMENTS = 8,
  parameter int unsigned INDEX    = 0
) (
  input  prru_pkg::stage_t      stage_i,
  input  logic [ELEMENTS-1:0]   used_i,
  output prru_pkg::stage_t      stage_o,
  output logic [ELEMENTS-1:0]   used_o
);
  import prru_pkg::*;

  localparam int unsigned ValW    = $clog2(ELEMENTS);
  localparam int unsigned Choices = ELEMENTS - INDEX;
  localparam longint unsigned Radix = factorial(ELEMENTS - 1 - INDEX);
  localparam logic [CodeW-1:0] Radix16 = CodeW'(Radix);

  logic [ValW-1:0]     digit;
  logic [CodeW-1:0]    digit_ext;
  logic [ValW-1:0]     pick;
  logic [ELEMENTS-1:0] low_mask;

  // Extract this position's digit by comparing against multiples of the radix.
  always_comb begin
    digit = '0;
    for (int unsigned m = 1; m < Choices; m++) begin
      if (64'(stage_i.rem) >= (longint'(m) * Radix)) begin
        digit = digit + ValW'(1);
      end
    end
  end

  assign digit_ext = CodeW'(digit);

  // Pick the free value that has exactly digit free values below it.
  always_comb begin
    pick     = '0;
    low_mask = '0;
    for (int unsigned y = 0; y < ELEMENTS; y++) begin
      low_mask = '0;
      for (int unsigned b = 0; b < y; b++) begin
        low_mask[b] = 1'b1;
      end
      if (!used_i[y] && (ValW'($countones(~used_i & low_mask)) == digit)) begin
        pick = ValW'(y);
      end
    end
  end

  // Mark the value as taken and place it in the packed permutation.
  always_comb begin
    used_o       = used_i;
    used_o[pick] = 1'b1;
    stage_o      = stage_i;
    stage_o.rem  = stage_i.rem - digit_ext * Radix16;
    stage_o.perm = stage_i.perm | (PermW'(pick) << (ElemW * INDEX));
  end

endmodule

/* design/permutation_rank_unrank_core.sv */
// Lehmer-code permutation converter. Opcode rank turns a packed permutation (3 bits per
// element, element 0 lowest) into its lexicographic rank; opcode unrank turns a rank back
// into the packed permutation. A repeated or out-of-range element, or a rank of ELEMENTS!
// or more, raises bad_input and gives zero results. One transfer is accepted every cycle
// while the output is not stalled; each result passes the register after the ranking lanes
// and then the per-element registers of the unranking digit chain, which set the depth.
// A stalled output freezes the whole pipeline.
module permutation_rank_unrank_core #(
  parameter int unsigned ELEMENTS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [prru_pkg::PermW-1:0]  perm_in_i,
  input  logic [prru_pkg::CodeW-1:0]  code_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [prru_pkg::CodeW-1:0]  code_out_o,
  output logic [prru_pkg::PermW-1:0]  perm_out_o,
  output logic                        bad_input_o
);
  import prru_pkg::*;

  localparam int unsigned     Depth     = ELEMENTS + 1;
  localparam longint unsigned CodeLimit = factorial(ELEMENTS);

  logic [ELEMENTS-1:0][ElemW-1:0] elems;
  logic [ELEMENTS-1:0][CodeW-1:0] terms;
  logic [ELEMENTS-1:0]            lane_bad;
  logic                           advance;
  logic                           in_bad;

  logic [Depth-1:0]               vld_q;
  op_e                            s0_op_q;
  logic                           s0_bad_q;
  logic [ELEMENTS-1:0][CodeW-1:0] s0_terms_q;
  logic [CodeW-1:0]               s0_code_q;
  logic [CodeW-1:0]               rank_sum;

  stage_t                         seed;
  stage_t                         stg_d    [ELEMENTS];
  stage_t                         stg_q    [ELEMENTS];
  logic [ELEMENTS-1:0]            used_d   [ELEMENTS];
  logic [ELEMENTS-1:0]            used_q   [ELEMENTS];

  // Unpack the elements; positions beyond the field read as zero.
  for (genvar g = 0; g < ELEMENTS; g++) begin : g_elem
    if (g < PermSlots) begin : g_field
      assign elems[g] = perm_in_i[ElemW*g +: ElemW];
    end else begin : g_zero
      assign elems[g] = '0;
    end
  end

  // Ranking lanes, one per position, all working on the same item.
  for (genvar g = 0; g < ELEMENTS; g++) begin : g_lane
    prru_lane #(
      .ELEMENTS (ELEMENTS),
      .INDEX    (g)
    ) u_lane (
      .elems_i (elems),
      .term_o  (terms[g]),
      .bad_o   (lane_bad[g])
    );
  end

  // Input rejection for either operation.
  assign in_bad = (op_e'(opcode_i) == OP_RANK) ? (|lane_bad)
                                               : (64'(code_in_i) >= CodeLimit);

  // The whole pipeline holds while a finished result waits to be taken.
  assign advance    = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o = !advance;

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // Lane stage payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s0_op_q    <= op_e'(opcode_i);
      s0_bad_q   <= in_bad;
      s0_terms_q <= terms;
      s0_code_q  <= code_in_i;
    end
  end

  // Merge the lane results into the rank.
  prru_merge #(
    .ELEMENTS (ELEMENTS)
  ) u_merge (
    .terms_i (s0_terms_q),
    .sum_o   (rank_sum)
  );

  // Seed of the unranking chain.
  always_comb begin
    seed      = '0;
    seed.op   = s0_op_q;
    seed.bad  = s0_bad_q;
    seed.code = rank_sum;
    seed.rem  = s0_code_q;
  end

  // Unranking chain: one position's digit and value per stage.
  for (genvar g = 0; g < ELEMENTS; g++) begin : g_pick
    if (g == 0) begin : g_first
      prru_pick #(
        .ELEMENTS (ELEMENTS),
        .INDEX    (g)
      ) u_pick (
        .stage_i (seed),
        .used_i  ('0),
        .stage_o (stg_d[g]),
        .used_o  (used_d[g])
      );
    end else begin : g_next
      prru_pick #(
        .ELEMENTS (ELEMENTS),
        .INDEX    (g)
      ) u_pick (
        .stage_i (stg_q[g-1]),
        .used_i  (used_q[g-1]),
        .stage_o (stg_d[g]),
        .used_o  (used_d[g])
      );
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        stg_q[g]  <= stg_d[g];
        used_q[g] <= used_d[g];
      end
    end
  end

  // Result of the last stage; the unused result field is forced to zero.
  assign out_valid_o = vld_q[Depth-1];
  assign bad_input_o = stg_q[ELEMENTS-1].bad;
  assign code_out_o  = (stg_q[ELEMENTS-1].op == OP_RANK && !stg_q[ELEMENTS-1].bad)
                       ? stg_q[ELEMENTS-1].code : '0;
  assign perm_out_o  = (stg_q[ELEMENTS-1].op == OP_UNRANK && !stg_q[ELEMENTS-1].bad)
                       ? stg_q[ELEMENTS-1].perm : '0;

endmodule

/* design/prru_checker.sv */
module prru_sva (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [prru_pkg::CodeW-1:0]  code_out_o,
  input logic [prru_pkg::PermW-1:0]  perm_out_o,
  input logic                        bad_input_o
);

  // A held result must back-pressure the input side.
  a_stall_propagates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input not stalled while a result is held");

  // The input side only stalls because of the output side.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without output stall");

  // A stalled result transfer keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_out_o)
      && $stable(perm_out_o) && $stable(bad_input_o))
    else $error("result changed while stalled");

  // A rejected input yields zero results.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_input_o |-> code_out_o == '0 && perm_out_o == '0)
    else $error("rejected input with non-zero result");

  // Only one of the two result fields can carry a value.
  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> code_out_o == '0 || perm_out_o == '0)
    else $error("both result fields non-zero");

endmodule

bind permutation_rank_unrank_core prru_sva u_prru_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .code_out_o  (code_out_o),
  .perm_out_o  (perm_out_o),
  .bad_input_o (bad_input_o)
);
